FILE: rtl/sparse_table_range_min_unit_defines.svh
// Assertion macros for the RTL of the range minimum unit.
`ifndef SPARSE_TABLE_RANGE_MIN_UNIT_DEFINES_SVH
`define SPARSE_TABLE_RANGE_MIN_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STM_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("%m: implication check failed");

// The consequent must hold in the cycle after the antecedent.
`define STM_ASSERT_NXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("%m: next-cycle check failed");

`endif

FILE: rtl/stm_pkg.sv
`timescale 1ns / 1ps

package stm_pkg;

  localparam int MAX_LEN     = 1024;
  localparam int LOG_LEN     = 10;
  localparam int VALUE_WIDTH = 32;
  localparam int LEVELS      = LOG_LEN + 1;

  localparam int IDX_W     = $clog2(MAX_LEN);
  localparam int CNT_W     = $clog2(MAX_LEN + 1);
  localparam int LVL_W     = $clog2(LEVELS + 1);
  localparam int TBL_DEPTH = LEVELS * MAX_LEN;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);
  localparam int VAL_AW    = $clog2(MAX_LEN);

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [LVL_W-1:0]       lvl_t;
  typedef logic [TBL_AW-1:0]      taddr_t;
  typedef logic [VALUE_WIDTH-1:0] value_t;

  // The table is laid out level by level, one row of MAX_LEN entries per level.
  function automatic taddr_t tbl_addr(lvl_t lvl, idx_t idx);
    tbl_addr = TBL_AW'(int'(lvl) * MAX_LEN + int'(idx));
  endfunction

  function automatic lvl_t floor_log2(cnt_t x);
    lvl_t r;
    r = '0;
    for (int b = 0; b < CNT_W; b++) begin
      if (x[b]) begin
        r = LVL_W'(b);
      end
    end
    if (r > LVL_W'(LOG_LEN)) begin
      r = LVL_W'(LOG_LEN);
    end
    return r;
  endfunction

endpackage

FILE: rtl/stm_ram.sv
`timescale 1ns / 1ps

module stm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a_i,
  output logic [WIDTH-1:0]         rd_data_a_o,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b_i,
  output logic [WIDTH-1:0]         rd_data_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_a_o <= mem_q[rd_addr_a_i];
    rd_data_b_o <= mem_q[rd_addr_b_i];
  end

endmodule

FILE: rtl/sparse_table_range_min_unit.sv
`timescale 1ns / 1ps

// Sparse table range minimum unit. Load items (command 0) are taken one per cycle while
// the unit is idle and stored in order, up to MAX_LEN items; the load marked last
// starts a build of the argmin table, during which no item is accepted. For each level
// j >= 1 with 2^j <= n, the build first checks the level and then takes each entry i
// with i + 2^j <= n through a table read, a value read, and a compare and write; a
// final level check ends the build. A query item (command 1) has its result registered
// after the log step, a table lookup followed by a value lookup through the registered
// read ports of the two memories, and a compare step; a refused query has its result
// registered from the log step. The result waits in an output register; a new result
// waits in its last step while the previous one is still held there. The next item can
// be accepted once the result appears, so no item is taken while a query is under way.
module sparse_table_range_min_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            command_i,
  input  logic signed [stm_pkg::VALUE_WIDTH-1:0] value_i,
  input  logic                            is_last_i,
  input  logic [stm_pkg::IDX_W-1:0]       left_i,
  input  logic [stm_pkg::IDX_W-1:0]       right_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [stm_pkg::IDX_W-1:0]       min_index_o,
  output logic                            query_error_o
);

  import stm_pkg::*;

  `include "sparse_table_range_min_unit_defines.svh"

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_Q_LOG   = 9'b000000010,
    ST_Q_TREAD = 9'b000000100,
    ST_Q_VREAD = 9'b000001000,
    ST_Q_CMP   = 9'b000010000,
    ST_B_LEVEL = 9'b000100000,
    ST_B_TREAD = 9'b001000000,
    ST_B_VREAD = 9'b010000000,
    ST_B_WRITE = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  cnt_t   count_q, count_d;
  logic   ready_q, ready_d;
  logic   out_valid_q, out_valid_d;
  idx_t   min_index_q, min_index_d;
  logic   query_error_q, query_error_d;

  lvl_t bj_q, bj_d;
  idx_t bi_q, bi_d;
  cnt_t n_q, n_d;
  lvl_t k_q, k_d;
  idx_t lo_q, lo_d;
  idx_t hi_q, hi_d;
  logic err_q, err_d;
  idx_t a_q, a_d;
  idx_t b_q, b_d;

  logic   accept;
  logic   load_acc;
  logic   load_store;
  cnt_t   cnt_base;
  cnt_t   cnt_new;
  idx_t   q_lo;
  idx_t   q_hi;
  logic   out_free;
  logic [CNT_W:0] pow_bj;
  cnt_t   half;
  idx_t   bi_half;
  idx_t   pos2;
  cnt_t   q_len;

  logic   tbl_we;
  taddr_t tbl_waddr;
  idx_t   tbl_wdata;
  taddr_t tbl_raddr_a, tbl_raddr_b;
  idx_t   tbl_rdata_a, tbl_rdata_b;
  logic   val_we;
  idx_t   val_raddr_a, val_raddr_b;
  value_t val_rdata_a, val_rdata_b;
  idx_t   build_win;
  idx_t   query_win;

  assign in_stall_o    = (state_q != ST_IDLE);
  assign accept        = in_valid_i && !in_stall_o;
  assign load_acc      = accept && (command_i == CMD_LOAD);
  assign cnt_base      = ready_q ? '0 : count_q;
  assign load_store    = load_acc && (cnt_base < CNT_W'(MAX_LEN));
  assign cnt_new       = cnt_base + CNT_W'(load_store);
  assign q_lo          = (left_i < right_i) ? left_i : right_i;
  assign q_hi          = (left_i < right_i) ? right_i : left_i;
  assign out_free      = !out_valid_q || !out_stall_i;

  assign pow_bj  = (CNT_W + 1)'(1) << bj_q;
  assign half    = CNT_W'(1) << (bj_q - LVL_W'(1));
  assign bi_half = IDX_W'(CNT_W'(bi_q) + half);
  assign pos2    = IDX_W'((CNT_W + 1)'(hi_q) + (CNT_W + 1)'(1) - ((CNT_W + 1)'(1) << k_q));
  assign q_len   = CNT_W'(hi_q) - CNT_W'(lo_q) + CNT_W'(1);

  assign build_win = ($signed(val_rdata_a) < $signed(val_rdata_b)) ? a_q : b_q;
  assign query_win = ($signed(val_rdata_a) > $signed(val_rdata_b)) ? b_q : a_q;

  always_comb begin
    tbl_we    = load_store;
    tbl_waddr = tbl_addr('0, cnt_base[IDX_W-1:0]);
    tbl_wdata = cnt_base[IDX_W-1:0];
    if (state_q == ST_B_WRITE) begin
      tbl_we    = 1'b1;
      tbl_waddr = tbl_addr(bj_q, bi_q);
      tbl_wdata = build_win;
    end
  end

  assign val_we = load_store;

  always_comb begin
    if (state_q == ST_Q_TREAD) begin
      tbl_raddr_a = tbl_addr(k_q, lo_q);
      tbl_raddr_b = tbl_addr(k_q, pos2);
    end else begin
      tbl_raddr_a = tbl_addr(bj_q - LVL_W'(1), bi_q);
      tbl_raddr_b = tbl_addr(bj_q - LVL_W'(1), bi_half);
    end
    if (state_q == ST_Q_VREAD || state_q == ST_B_VREAD) begin
      val_raddr_a = tbl_rdata_a;
      val_raddr_b = tbl_rdata_b;
    end else begin
      val_raddr_a = a_q;
      val_raddr_b = b_q;
    end
  end

  stm_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(MAX_LEN)
  ) u_values (
    .clk_i      (clk_i),
    .wr_en_i    (val_we),
    .wr_addr_i  (VAL_AW'(cnt_base[IDX_W-1:0])),
    .wr_data_i  (value_i),
    .rd_addr_a_i(VAL_AW'(val_raddr_a)),
    .rd_data_a_o(val_rdata_a),
    .rd_addr_b_i(VAL_AW'(val_raddr_b)),
    .rd_data_b_o(val_rdata_b)
  );

  stm_ram #(
    .WIDTH(IDX_W),
    .DEPTH(TBL_DEPTH)
  ) u_table (
    .clk_i      (clk_i),
    .wr_en_i    (tbl_we),
    .wr_addr_i  (tbl_waddr),
    .wr_data_i  (tbl_wdata),
    .rd_addr_a_i(tbl_raddr_a),
    .rd_data_a_o(tbl_rdata_a),
    .rd_addr_b_i(tbl_raddr_b),
    .rd_data_b_o(tbl_rdata_b)
  );

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    ready_d       = ready_q;
    out_valid_d   = out_valid_q && out_stall_i;
    min_index_d   = min_index_q;
    query_error_d = query_error_q;
    bj_d          = bj_q;
    bi_d          = bi_q;
    n_d           = n_q;
    k_d           = k_q;
    lo_d          = lo_q;
    hi_d          = hi_q;
    err_d         = err_q;
    a_d           = a_q;
    b_d           = b_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (command_i == CMD_QUERY) begin
            lo_d    = q_lo + IDX_W'(1);
            hi_d    = q_hi;
            err_d   = !ready_q || (q_lo == q_hi) || (CNT_W'(q_hi) >= count_q);
            state_d = ST_Q_LOG;
          end else begin
            count_d = cnt_new;
            ready_d = 1'b0;
            if (is_last_i) begin
              n_d     = cnt_new;
              bj_d    = LVL_W'(1);
              state_d = ST_B_LEVEL;
            end
          end
        end
      end
      ST_Q_LOG: begin
        if (err_q) begin
          if (out_free) begin
            out_valid_d   = 1'b1;
            min_index_d   = '0;
            query_error_d = 1'b1;
            state_d       = ST_IDLE;
          end
        end else begin
          k_d     = floor_log2(q_len);
          state_d = ST_Q_TREAD;
        end
      end
      ST_Q_TREAD: begin
        state_d = ST_Q_VREAD;
      end
      ST_Q_VREAD: begin
        a_d     = tbl_rdata_a;
        b_d     = tbl_rdata_b;
        state_d = ST_Q_CMP;
      end
      ST_Q_CMP: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          min_index_d   = query_win;
          query_error_d = 1'b0;
          state_d       = ST_IDLE;
        end
      end
      ST_B_LEVEL: begin
        if (bj_q <= LVL_W'(LOG_LEN) && pow_bj <= (CNT_W + 1)'(n_q)) begin
          bi_d    = '0;
          state_d = ST_B_TREAD;
        end else begin
          ready_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_B_TREAD: begin
        state_d = ST_B_VREAD;
      end
      ST_B_VREAD: begin
        a_d     = tbl_rdata_a;
        b_d     = tbl_rdata_b;
        state_d = ST_B_WRITE;
      end
      ST_B_WRITE: begin
        if ((CNT_W + 1)'(bi_q) + (CNT_W + 1)'(1) + pow_bj <= (CNT_W + 1)'(n_q)) begin
          bi_d    = bi_q + IDX_W'(1);
          state_d = ST_B_TREAD;
        end else begin
          bj_d    = bj_q + LVL_W'(1);
          state_d = ST_B_LEVEL;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      ready_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ready_q     <= ready_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    min_index_q   <= min_index_d;
    query_error_q <= query_error_d;
    bj_q          <= bj_d;
    bi_q          <= bi_d;
    n_q           <= n_d;
    k_q           <= k_d;
    lo_q          <= lo_d;
    hi_q          <= hi_d;
    err_q         <= err_d;
    a_q           <= a_d;
    b_q           <= b_d;
  end

  assign out_valid_o   = out_valid_q;
  assign min_index_o   = min_index_q;
  assign query_error_o = query_error_q;

  `STM_ASSERT_IMP(a_tbl_write_src, clk_i, rst_ni, tbl_we,
      (state_q == ST_IDLE) || (state_q == ST_B_WRITE))

  `STM_ASSERT_IMP(a_result_src, clk_i, rst_ni, $rose(out_valid_q),
      ($past(state_q) == ST_Q_LOG) || ($past(state_q) == ST_Q_CMP))

  `STM_ASSERT_NXT(a_build_count_hold, clk_i, rst_ni,
      (state_q == ST_B_LEVEL) || (state_q == ST_B_TREAD) ||
      (state_q == ST_B_VREAD) || (state_q == ST_B_WRITE), $stable(count_q))

  `STM_ASSERT_IMP(a_ready_src, clk_i, rst_ni, $rose(ready_q),
      $past(state_q) == ST_B_LEVEL)

endmodule
